// File: rtl/core/servo_setpoint_filter_unit_assert.svh
// Assertion macros used by the checker of the setpoint filter.
// Depends on nothing; the including module provides i_clk and i_rst_n.
`ifndef SERVO_SETPOINT_FILTER_UNIT_ASSERT_SVH
`define SERVO_SETPOINT_FILTER_UNIT_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define SSF_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ssf assertion failed");

// Next-cycle implication, checked outside reset.
`define SSF_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ssf assertion failed");

`endif

// File: rtl/core/ssf_pkg.sv
// Shared types, constants and a helper function of the setpoint filter.
// Depends on nothing; used by the top level and its checker.
package ssf_pkg;

    localparam int NUM_JOINTS = 6;
    localparam int JIDX_W     = (NUM_JOINTS > 1) ? $clog2(NUM_JOINTS) : 1;

    localparam int ENTRY_W = 96;   // {velocity, position, raw target}
    localparam int DT_W    = 17;

    localparam logic [40:0] DT_LIMIT   = 41'd104857;
    localparam logic [DT_W-1:0] DT_DEFAULT = 17'd1049;

    localparam logic [31:0] NFS_RESET      = 32'd163840000;
    localparam logic [31:0] DAMPING_RESET  = 32'd6553600;
    localparam logic [30:0] MAX_STEP_RESET = 31'd104858;

    localparam logic [1:0] OP_START  = 2'd0;
    localparam logic [1:0] OP_UPDATE = 2'd1;
    localparam logic [1:0] OP_STEP   = 2'd2;

    localparam logic [1:0] CFG_NFS      = 2'd0;
    localparam logic [1:0] CFG_DAMPING  = 2'd1;
    localparam logic [1:0] CFG_MAX_STEP = 2'd2;

    typedef enum logic [3:0] {
        ST_IDLE, ST_URD, ST_ULD, ST_RD, ST_LD,
        ST_M0, ST_M1, ST_M2, ST_M3, ST_M4, ST_M5,
        ST_V0, ST_V1, ST_P0, ST_P1, ST_EMIT
    } t_state;

    // Saturate a wide signed value to 32 bits.
    function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
        logic signed [31:0] r;
        if (v > 66'sd2147483647)
            r = 32'sh7FFFFFFF;
        else if (v < -66'sd2147483648)
            r = 32'sh80000000;
        else
            r = v[31:0];
        return r;
    endfunction

endpackage

// File: rtl/core/servo_setpoint_filter_unit.sv
// Top level of the servo setpoint filter: sequencer, arithmetic and joint memory.
// Depends on ssf_pkg and ssf_ram.
//
// Usage. Input words arrive on the s channel: tuser carries the operation
// (start, update, step), tdata the joint, target, measured position and time
// stamp. Start and update words change one joint's entry and give no output.
// A step word advances every joint by one filter step and gives one output
// word per joint on the m channel, joints in ascending order, tlast on the
// final joint.
// Sequencing. A start writes the joint memory as it is accepted; an update
// reads, modifies and writes the joint memory. A step keeps the sequencer busy
// through every joint in turn: read, load, acceleration, velocity, position,
// acceleration again, emit; ten passes through the one shared 34 x 18 bit
// multiplier per joint. One word is processed at a time: s_tready is high only
// while the sequencer is idle.
// Stalls. The output register holds its word until m_tready; while it is full
// the sequencer waits before emitting the next joint. Idle input words may be
// taken while the last output word still waits.
// Reset. Synchronous, active low: the control and configuration registers
// take their default values, the time history is cleared and no output is
// valid. Joint entries are undefined until a start word writes them.
module servo_setpoint_filter_unit
    import ssf_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    // Input stream.
    input  logic          i_s_tvalid,
    output logic          o_s_tready,
    // tdata, low bit up: joint[3:0], target_position[31:0],
    // measured_position[31:0], time_stamp[39:0], zero pad[3:0].
    input  logic [111:0]  i_s_tdata,
    // tuser: operation[1:0].
    input  logic [1:0]    i_s_tuser,
    // Output stream.
    output logic          o_m_tvalid,
    input  logic          i_m_tready,
    // tdata, low bit up: joint_out[3:0], position_out[31:0],
    // velocity_out[31:0], acceleration_out[31:0], zero pad[3:0].
    output logic [103:0]  o_m_tdata,
    output logic          o_m_tlast,
    // Configuration write port.
    input  logic          i_cfg_we,
    input  logic [1:0]    i_cfg_idx,
    input  logic [31:0]   i_cfg_data
);

    // Input fields.
    logic [3:0]         in_joint;
    logic signed [31:0] in_target;
    logic signed [31:0] in_measured;
    logic [39:0]        in_time;
    assign in_joint    = i_s_tdata[3:0];
    assign in_target   = i_s_tdata[35:4];
    assign in_measured = i_s_tdata[67:36];
    assign in_time     = i_s_tdata[107:68];

    // Configuration registers.
    logic [31:0] r_nfs;
    logic [31:0] r_damping;
    logic [30:0] r_max_step;

    // Control state.
    t_state            r_state, n_state;
    logic [JIDX_W-1:0] r_j;
    logic              r_second;
    logic              r_time_seen;
    logic [39:0]       r_prev_time;
    logic              r_out_valid;

    // Datapath registers.
    logic signed [31:0] r_tgt;
    logic signed [31:0] r_raw, r_pos, r_vel, r_a;
    logic [DT_W-1:0]    r_dt;
    logic signed [51:0] r_prod;
    logic signed [65:0] r_acc1, r_acc2;
    logic [103:0]       r_out_data;
    logic               r_out_last;

    // Memory port signals.
    logic               mem_we;
    logic [JIDX_W-1:0]  mem_waddr;
    logic [ENTRY_W-1:0] mem_wdata;
    logic [ENTRY_W-1:0] mem_rdata;

    logic in_fire;
    logic joint_ok;
    logic slot_free;
    logic last_joint;
    assign in_fire    = i_s_tvalid && o_s_tready;
    assign joint_ok   = ({1'b0, in_joint} < 5'(NUM_JOINTS));
    assign slot_free  = !r_out_valid || i_m_tready;
    assign last_joint = (r_j == JIDX_W'(NUM_JOINTS - 1));

    // Clamp a target to within max_step of a reference; the result always
    // lies between the two, so it fits in 32 bits.
    function automatic logic signed [31:0] clamp_to(
        input logic signed [31:0] tgt,
        input logic signed [31:0] ref_pos,
        input logic [30:0]        max_step
    );
        logic signed [32:0] d;
        logic signed [32:0] m;
        logic signed [32:0] q;
        d = 33'(tgt) - 33'(ref_pos);
        m = {2'b00, max_step};
        if (d > m)
            d = m;
        if (d < -m)
            d = -m;
        q = 33'(ref_pos) + d;
        return q[31:0];
    endfunction

    // Time step: the first step and any out-of-range difference use 1 ms.
    logic [39:0]        prev_eff;
    logic signed [40:0] dt_full;
    logic [DT_W-1:0]    dt_next;
    assign prev_eff = r_time_seen ? r_prev_time : in_time;
    assign dt_full  = $signed({1'b0, in_time}) - $signed({1'b0, prev_eff});
    assign dt_next  = (dt_full <= 41'sd0 || dt_full > $signed(DT_LIMIT))
                      ? DT_DEFAULT : dt_full[DT_W-1:0];

    // Shared multiplier operands.
    logic signed [32:0] diff;
    logic signed [33:0] mul_a;
    logic signed [17:0] mul_b;
    logic signed [65:0] prod_ext;
    assign diff     = 33'(r_raw) - 33'(r_pos);
    assign prod_ext = {{14{r_prod[51]}}, r_prod};

    always_comb begin
        mul_a = 34'(r_vel);
        mul_b = {1'b0, r_dt};
        case (r_state)
            ST_M0: begin
                mul_a = 34'(diff);
                mul_b = {2'b00, r_nfs[15:0]};
            end
            ST_M1: begin
                mul_a = 34'(diff);
                mul_b = {2'b00, r_nfs[31:16]};
            end
            ST_M2: begin
                mul_b = {2'b00, r_damping[15:0]};
            end
            ST_M3: begin
                mul_b = {2'b00, r_damping[31:16]};
            end
            ST_V0: begin
                mul_a = 34'(r_a);
            end
            default: begin
                mul_a = 34'(r_vel);
            end
        endcase
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (in_fire && i_s_tuser == OP_UPDATE && joint_ok)
                    n_state = ST_URD;
                else if (in_fire && i_s_tuser == OP_STEP)
                    n_state = ST_RD;
            end
            ST_URD:  n_state = ST_ULD;
            ST_ULD:  n_state = ST_IDLE;
            ST_RD:   n_state = ST_LD;
            ST_LD:   n_state = ST_M0;
            ST_M0:   n_state = ST_M1;
            ST_M1:   n_state = ST_M2;
            ST_M2:   n_state = ST_M3;
            ST_M3:   n_state = ST_M4;
            ST_M4:   n_state = ST_M5;
            ST_M5:   n_state = r_second ? ST_EMIT : ST_V0;
            ST_V0:   n_state = ST_V1;
            ST_V1:   n_state = ST_P0;
            ST_P0:   n_state = ST_P1;
            ST_P1:   n_state = ST_M0;
            ST_EMIT: begin
                if (slot_free)
                    n_state = last_joint ? ST_IDLE : ST_RD;
            end
            default: n_state = ST_IDLE;
        endcase
    end

    // Outputs of the sequencer: memory writes and input ready.
    always_comb begin
        mem_we    = 1'b0;
        mem_waddr = r_j;
        mem_wdata = {r_vel, r_pos, r_raw};
        o_s_tready = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                o_s_tready = 1'b1;
                if (in_fire && i_s_tuser == OP_START && joint_ok) begin
                    mem_we    = 1'b1;
                    mem_waddr = in_joint[JIDX_W-1:0];
                    mem_wdata = {32'd0,
                                 clamp_to(in_target, in_measured, r_max_step),
                                 clamp_to(in_target, in_measured, r_max_step)};
                end
            end
            ST_ULD: begin
                mem_we    = 1'b1;
                mem_wdata = {mem_rdata[95:32],
                             clamp_to(r_tgt, $signed(mem_rdata[63:32]), r_max_step)};
            end
            ST_EMIT: begin
                mem_we = slot_free;
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    ssf_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_JOINTS)
    ) u_joint_ram (
        .i_clk   (i_clk),
        .i_we    (mem_we),
        .i_waddr (mem_waddr),
        .i_wdata (mem_wdata),
        .i_raddr (r_j),
        .o_rdata (mem_rdata)
    );

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_j         <= '0;
            r_second    <= 1'b0;
            r_time_seen <= 1'b0;
            r_prev_time <= '0;
            r_out_valid <= 1'b0;
            r_nfs       <= NFS_RESET;
            r_damping   <= DAMPING_RESET;
            r_max_step  <= MAX_STEP_RESET;
        end else begin
            r_state <= n_state;
            if (i_cfg_we) begin
                unique case (i_cfg_idx)
                    CFG_NFS:      r_nfs      <= i_cfg_data;
                    CFG_DAMPING:  r_damping  <= i_cfg_data;
                    CFG_MAX_STEP: r_max_step <= i_cfg_data[30:0];
                    default:      r_nfs      <= r_nfs;
                endcase
            end
            if (in_fire && i_s_tuser == OP_UPDATE)
                r_j <= in_joint[JIDX_W-1:0];
            if (in_fire && i_s_tuser == OP_STEP) begin
                r_j         <= '0;
                r_time_seen <= 1'b1;
                r_prev_time <= in_time;
            end
            if (r_state == ST_LD)
                r_second <= 1'b0;
            if (r_state == ST_P1)
                r_second <= 1'b1;
            if (r_state == ST_EMIT && slot_free && !last_joint)
                r_j <= r_j + JIDX_W'(1);
            if (r_state == ST_EMIT && slot_free)
                r_out_valid <= 1'b1;
            else if (i_m_tready)
                r_out_valid <= 1'b0;
        end
    end

    // Datapath registers.
    always_ff @(posedge i_clk) begin
        r_prod <= mul_a * mul_b;
        if (in_fire) begin
            r_tgt <= in_target;
            r_dt  <= (i_s_tuser == OP_STEP) ? dt_next : r_dt;
        end
        case (r_state)
            ST_LD: begin
                r_raw <= mem_rdata[31:0];
                r_pos <= mem_rdata[63:32];
                r_vel <= mem_rdata[95:64];
            end
            ST_M1: r_acc1 <= prod_ext;
            ST_M2: r_acc1 <= r_acc1 + (prod_ext <<< 16);
            ST_M3: r_acc2 <= prod_ext;
            ST_M4: r_acc2 <= r_acc2 + (prod_ext <<< 16);
            ST_M5: r_a    <= sat32((r_acc1 >>> 16) - (r_acc2 >>> 16));
            ST_V1: r_vel  <= sat32(66'(r_vel) + (prod_ext >>> 20));
            ST_P1: r_pos  <= sat32(66'(r_pos) + (prod_ext >>> 20));
            ST_EMIT: begin
                if (slot_free) begin
                    r_out_data <= {4'd0, r_a, r_vel, r_pos, 4'(r_j)};
                    r_out_last <= last_joint;
                end
            end
            default: begin
                r_a <= r_a;
            end
        endcase
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tlast  = r_out_last;

endmodule

// File: rtl/core/ssf_ram.sv
// Generic simple dual-port RAM with a registered read.
// Depends on nothing.
module ssf_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic                                    i_clk,
    input  logic                                    i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                        i_wdata,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                        o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule

// File: rtl/core/ssf_checker.sv
// Port-level checker of the setpoint filter and its bind to the top level.
// Depends on ssf_pkg and servo_setpoint_filter_unit_assert.svh.
`include "servo_setpoint_filter_unit_assert.svh"

module ssf_checker
    import ssf_pkg::*;
(
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_s_tvalid,
    input logic         o_s_tready,
    input logic [1:0]   i_s_tuser,
    input logic         o_m_tvalid,
    input logic         i_m_tready,
    input logic [103:0] o_m_tdata,
    input logic         o_m_tlast
);
    // A stalled output word must not change.
    `SSF_ASSERT_NEXT(a_out_hold, o_m_tvalid && !i_m_tready, o_m_tvalid && $stable(o_m_tdata) && $stable(o_m_tlast))
    // Only the final joint of a step carries tlast.
    `SSF_ASSERT_IMP(a_last_joint, o_m_tvalid && o_m_tlast, o_m_tdata[3:0] == 4'(NUM_JOINTS - 1))
    // A step word occupies the sequencer on the following cycle.
    `SSF_ASSERT_NEXT(a_step_busy, i_s_tvalid && o_s_tready && i_s_tuser == OP_STEP, !o_s_tready)
endmodule

bind servo_setpoint_filter_unit ssf_checker u_ssf_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .i_s_tvalid (i_s_tvalid),
    .o_s_tready (o_s_tready),
    .i_s_tuser  (i_s_tuser),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata),
    .o_m_tlast  (o_m_tlast)
);

// File: tb/tb_servo_setpoint_filter_unit.sv
// Testbench for servo_setpoint_filter_unit: streams start, update and step words,
// predicts each joint output word in a behavioral model and checks it field by field.
// Depends on ssf_pkg and the RTL of the filter unit.
`timescale 1ns / 1ps

module tb_servo_setpoint_filter_unit;
    import ssf_pkg::*;

    localparam int SETTLE_CYCLES = 140;      // longer than one full step of six joints
    localparam int CYCLE_LIMIT   = 800000;
    localparam logic [1:0] OP_NOISE = 2'd3;  // unknown operation, ignored by the block

    typedef struct {
        logic [1:0]         op;
        logic [3:0]         joint;
        logic signed [31:0] target;
        logic signed [31:0] measured;
        logic [39:0]        stamp;
    } t_cmd_word;

    typedef struct {
        logic [3:0]         joint;
        logic signed [31:0] pos;
        logic signed [31:0] vel;
        logic signed [31:0] acc;
        logic               last;
    } t_joint_word;

    logic          i_clk = 1'b0;
    logic          i_rst_n = 1'b0;
    logic          i_s_tvalid = 1'b0;
    logic          o_s_tready;
    logic [111:0]  i_s_tdata = '0;
    logic [1:0]    i_s_tuser = '0;
    logic          o_m_tvalid;
    logic          i_m_tready = 1'b0;
    logic [103:0]  o_m_tdata;
    logic          o_m_tlast;
    logic          i_cfg_we = 1'b0;
    logic [1:0]    i_cfg_idx = '0;
    logic [31:0]   i_cfg_data = '0;

    servo_setpoint_filter_unit DUT (.*);

    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Behavioral copy of the filter state and its gains.
    logic [31:0]        gain_nfs;
    logic [31:0]        gain_damp;
    logic [30:0]        step_limit;
    logic signed [31:0] joint_goal  [NUM_JOINTS];
    logic signed [31:0] joint_angle [NUM_JOINTS];
    logic signed [31:0] joint_vel   [NUM_JOINTS];
    logic [39:0]        last_stamp;
    logic               stamp_valid;

    t_cmd_word   cmd_queue[$];
    t_joint_word joint_words_due[$];
    t_cmd_word   cmd_cur;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    int          mismatches = 0;
    int          cycle_count = 0;

    function automatic logic signed [31:0] sat_word(input longint v);
        if (v > 64'sd2147483647) return 32'sh7FFFFFFF;
        if (v < -64'sd2147483648) return 32'sh80000000;
        return v[31:0];
    endfunction

    // Q16.16 gain times a value; the fractional part is floored back.
    function automatic longint gain_mul(input logic [31:0] k, input longint x);
        longint hi;
        longint lo;
        hi = longint'(k[31:16]);
        lo = longint'(k[15:0]);
        return hi * x + ((lo * x) >>> 16);
    endfunction

    function automatic logic signed [31:0] joint_accel(input int j);
        longint diff;
        diff = longint'(joint_goal[j]) - longint'(joint_angle[j]);
        return sat_word(gain_mul(gain_nfs, diff) - gain_mul(gain_damp, longint'(joint_vel[j])));
    endfunction

    function automatic logic signed [31:0] clamp_goal(input longint goal, input longint anchor);
        longint d;
        d = goal - anchor;
        if (d > longint'(step_limit)) d = longint'(step_limit);
        if (d < -longint'(step_limit)) d = -longint'(step_limit);
        return 32'(anchor + d);
    endfunction

    // Applies one accepted input word and queues the joint words it causes.
    task automatic apply_cmd(input t_cmd_word c);
        longint      dt;
        logic signed [31:0] a;
        t_joint_word r;
        if (c.op == OP_START && c.joint < NUM_JOINTS) begin
            joint_goal[c.joint]  = clamp_goal(longint'(c.target), longint'(c.measured));
            joint_angle[c.joint] = joint_goal[c.joint];
            joint_vel[c.joint]   = 0;
        end else if (c.op == OP_UPDATE && c.joint < NUM_JOINTS) begin
            joint_goal[c.joint] = clamp_goal(longint'(c.target), longint'(joint_angle[c.joint]));
        end else if (c.op == OP_STEP) begin
            if (!stamp_valid) begin
                last_stamp  = c.stamp;
                stamp_valid = 1'b1;
            end
            dt = longint'({24'd0, c.stamp}) - longint'({24'd0, last_stamp});
            last_stamp = c.stamp;
            // A stalled, backward or overlong time step falls back to one millisecond.
            if (dt <= 0 || dt > 104857) dt = 1049;
            for (int j = 0; j < NUM_JOINTS; j++) begin
                a = joint_accel(j);
                joint_vel[j] = sat_word(longint'(joint_vel[j]) + ((dt * longint'(a)) >>> 20));
                joint_angle[j] = sat_word(longint'(joint_angle[j])
                                          + ((dt * longint'(joint_vel[j])) >>> 20));
                r.joint = 4'(j);
                r.pos   = joint_angle[j];
                r.vel   = joint_vel[j];
                r.acc   = joint_accel(j);
                r.last  = (j == NUM_JOINTS - 1);
                joint_words_due.push_back(r);
            end
        end
    endtask

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("MISMATCH %s: got %h, expected %h", what, got, want);
        mismatches++;
    endtask

    // Driver: presents queued words, keeps tvalid steady until each is taken.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_s_tvalid <= 1'b0;
        end else if (!i_s_tvalid || o_s_tready) begin
            if (i_s_tvalid) begin
                apply_cmd(cmd_cur);
            end
            if (cmd_queue.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
                cmd_cur = cmd_queue.pop_front();
                i_s_tvalid <= 1'b1;
                i_s_tuser  <= cmd_cur.op;
                i_s_tdata  <= {4'd0, cmd_cur.stamp, cmd_cur.measured, cmd_cur.target,
                               cmd_cur.joint};
            end else begin
                i_s_tvalid <= 1'b0;
            end
        end
    end

    // Receiver back-pressure.
    always @(posedge i_clk) begin
        i_m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Monitor: every accepted output word against the oldest expectation.
    always @(posedge i_clk) begin
        t_joint_word w;
        if (i_rst_n && o_m_tvalid && i_m_tready) begin
            if (joint_words_due.size() == 0) begin
                report_mismatch("unexpected word", {28'd0, o_m_tdata[3:0]}, 32'd0);
            end else begin
                w = joint_words_due.pop_front();
                if (o_m_tdata[3:0] != w.joint)
                    report_mismatch("joint", {28'd0, o_m_tdata[3:0]}, {28'd0, w.joint});
                if (o_m_tdata[35:4] != w.pos)
                    report_mismatch("position", o_m_tdata[35:4], w.pos);
                if (o_m_tdata[67:36] != w.vel)
                    report_mismatch("velocity", o_m_tdata[67:36], w.vel);
                if (o_m_tdata[99:68] != w.acc)
                    report_mismatch("acceleration", o_m_tdata[99:68], w.acc);
                if (o_m_tlast != w.last)
                    report_mismatch("tlast", {31'd0, o_m_tlast}, {31'd0, w.last});
            end
        end
    end

    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("tb_servo_setpoint_filter_unit NOT OK");
            $finish;
        end
    end

    // Register writes happen only with the block idle, so the model follows at once.
    task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
        @(posedge i_clk);
        i_cfg_we   <= 1'b1;
        i_cfg_idx  <= idx;
        i_cfg_data <= val;
        if (idx == CFG_NFS) gain_nfs = val;
        else if (idx == CFG_DAMPING) gain_damp = val;
        else if (idx == CFG_MAX_STEP) step_limit = val[30:0];
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic drain;
        while (cmd_queue.size() > 0 || i_s_tvalid || joint_words_due.size() > 0)
            @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic push_cmd(input logic [1:0] op, input logic [3:0] j,
                            input logic [31:0] tgt, input logic [31:0] meas,
                            input logic [39:0] ts);
        t_cmd_word c;
        c.op = op; c.joint = j; c.target = tgt; c.measured = meas; c.stamp = ts;
        cmd_queue.push_back(c);
    endtask

    logic [39:0] stamp_now = '0;

    function automatic logic [31:0] rand_angle();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom_range(1, 0) ? 32'h7FFFFFFF - $urandom_range(300000)
                                           : 32'h80000000 + $urandom_range(300000);
            default: return 32'($signed($urandom_range(4000000)) - 2000000);
        endcase
    endfunction

    // One random word; steps and updates only once every joint has been started.
    task automatic push_random;
        int sel;
        logic [39:0] ts;
        sel = $urandom_range(99);
        if (sel < 15) begin
            push_cmd(OP_START, 4'($urandom_range(NUM_JOINTS - 1)), rand_angle(),
                     rand_angle(), 40'({$urandom, $urandom}));
        end else if (sel < 55) begin
            push_cmd(OP_UPDATE, 4'($urandom_range(NUM_JOINTS - 1)), rand_angle(),
                     $urandom, 40'({$urandom, $urandom}));
        end else if (sel < 92) begin
            case ($urandom_range(9))
                0: ts = stamp_now - $urandom_range(1000);
                1: ts = stamp_now + 40'd104857 + $urandom;
                2: ts = 40'({$urandom, $urandom});
                default: ts = stamp_now + $urandom_range(1, 104857);
            endcase
            stamp_now = ts;
            push_cmd(OP_STEP, 4'($urandom), $urandom, $urandom, ts);
        end else if (sel < 96) begin
            push_cmd(OP_NOISE, 4'($urandom), $urandom, $urandom, 40'({$urandom, $urandom}));
        end else begin
            // Out-of-range joint index: ignored by the block.
            push_cmd(2'($urandom_range(1)), 4'($urandom_range(15, NUM_JOINTS)),
                     $urandom, $urandom, 40'({$urandom, $urandom}));
        end
    endtask

    initial begin
        gain_nfs    = NFS_RESET;
        gain_damp   = DAMPING_RESET;
        step_limit  = MAX_STEP_RESET;
        last_stamp  = '0;
        stamp_valid = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: start every joint with clamping both ways and without.
        push_cmd(OP_START, 4'd0, 32'h7FFFFFFF, 32'h80000000, '0);
        push_cmd(OP_START, 4'd1, 32'h80000000, 32'h7FFFFFFF, '0);
        push_cmd(OP_START, 4'd2, 32'd5000, 32'd5000, '0);
        push_cmd(OP_START, 4'd3, 32'h7FFFFFFF, 32'h7FFF0000, '1);
        push_cmd(OP_START, 4'd4, 32'h80000000, 32'h80010000, '0);
        push_cmd(OP_START, 4'd5, 32'hFFF00000, 32'h00100000, '0);
        push_cmd(OP_START, 4'd15, 32'd1, 32'd1, '0);     // joint out of range
        push_cmd(OP_UPDATE, 4'd7, 32'd1, 32'd1, '0);     // joint out of range
        push_cmd(OP_NOISE, 4'd0, 32'd0, 32'd0, '0);      // unknown operation
        push_cmd(OP_UPDATE, 4'd2, 32'h7FFFFFFF, 32'hFFFFFFFF, '1);
        push_cmd(OP_UPDATE, 4'd5, 32'h80000000, 32'd0, '0);
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, 40'd1000);          // first step
        push_cmd(OP_STEP, 4'd15, '1, '1, 40'd1000);               // zero time step
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, 40'd1000 + 40'd104857);  // longest valid
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, 40'd1000 + 40'd209715);  // just too long
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, 40'd500);           // backward in time
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, 40'd501);           // smallest step
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, '1);                // largest stamp
        push_cmd(OP_STEP, 4'd0, 32'd0, 32'd0, '0);                // wraps back
        stamp_now = '0;
        drain();

        for (int ph = 1; ph <= 4; ph++) begin
            case (ph)
                1: begin
                    write_reg(CFG_NFS, 32'd0);
                    write_reg(CFG_DAMPING, 32'd0);
                    write_reg(CFG_MAX_STEP, 32'h7FFFFFFF);
                    send_idle_pct = 0;  recv_stall_pct = 0;
                end
                2: begin
                    write_reg(CFG_NFS, 32'hFFFFFFFF);
                    write_reg(CFG_DAMPING, 32'hFFFFFFFF);
                    write_reg(CFG_MAX_STEP, 32'h80000000);   // top bit is not stored
                    send_idle_pct = 57; recv_stall_pct = 0;
                end
                3: begin
                    write_reg(CFG_NFS, $urandom_range(32'h4000000, 32'h100000));
                    write_reg(CFG_DAMPING, $urandom_range(32'h1000000, 32'h10000));
                    write_reg(CFG_MAX_STEP, $urandom);
                    send_idle_pct = 0;  recv_stall_pct = 57;
                end
                default: begin
                    write_reg(CFG_NFS, NFS_RESET);
                    write_reg(CFG_DAMPING, DAMPING_RESET);
                    write_reg(CFG_MAX_STEP, {1'b0, MAX_STEP_RESET});
                    send_idle_pct = 32; recv_stall_pct = 32;
                end
            endcase
            for (int n = 0; n < 85; n++) begin
                push_random();
                // Mid-phase the sender holds off until every output word has come.
                if (ph == 2 && n == 40) drain();
            end
            drain();
        end

        if (mismatches == 0) begin
            $display("tb_servo_setpoint_filter_unit OK");
        end else begin
            $display("tb_servo_setpoint_filter_unit NOT OK");
        end
        $finish;
    end

endmodule

// File: filelist.f
+incdir+rtl/core
rtl/core/ssf_pkg.sv
rtl/core/ssf_ram.sv
rtl/core/servo_setpoint_filter_unit.sv
rtl/core/ssf_checker.sv
tb/tb_servo_setpoint_filter_unit.sv
